// ===== design/mtne_pkg.sv =====
`default_nettype none
package mtne_pkg;

   localparam int PENDING_DEPTH_DEF = 32;
   localparam int TICK_BITS_DEF     = 32;
   localparam int FRACTION_BITS_DEF = 16;

   localparam int BEAT_W  = 48;
   localparam int TEMPO_W = 24;
   localparam int VEL_W   = 16;
   localparam int KIND_W  = 3;
   localparam int TPQ_W   = 15;
   localparam int NUM_W   = 32;
   localparam int NBC_W   = 3;

   localparam logic [TPQ_W-1:0] TPQ_RESET     = 15'd480;
   localparam logic [NBC_W-1:0] NUM_MAX_BYTES = 3'd4;

   localparam logic [7:0] META_STATUS  = 8'hFF;
   localparam logic [7:0] SYSEX_STATUS = 8'hF0;
   localparam logic [7:0] SYSEX_ESCAPE = 8'hF7;
   localparam logic [7:0] TEMPO_TYPE   = 8'h51;
   localparam logic [3:0] NIB_OFF      = 4'h8;
   localparam logic [3:0] NIB_ON       = 4'h9;
   localparam logic [3:0] NIB_PROGRAM  = 4'hC;
   localparam logic [3:0] NIB_PRESSURE = 4'hD;

   typedef enum logic [2:0] {
      KIND_NOTE,
      KIND_TEMPO,
      KIND_RS_ERR,
      KIND_TRUNC,
      KIND_FULL
   } kind_type;

   typedef enum logic [3:0] {
      PH_DELTA,
      PH_STATUS,
      PH_ONE_DATA,
      PH_DATA1,
      PH_DATA2,
      PH_META_TYPE,
      PH_META_LEN,
      PH_TEMPO,
      PH_SYSEX_LEN,
      PH_SKIP
   } phase_type;

   typedef enum logic [3:0] {
      SQ_IDLE,
      SQ_IMM,
      SQ_CLOSE,
      SQ_DIV,
      SQ_NOTE,
      SQ_OPEN,
      SQ_EOT,
      SQ_FLUSH,
      SQ_FINISH
   } seq_state_type;

   typedef struct packed {
      logic [3:0] ch;
      logic [7:0] pitch;
      logic [7:0] vel;
   } entry_type;

   typedef struct packed {
      logic [3:0] ch;
      logic [7:0] pitch;
   } key_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic occupied;
   } cell_ctl_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [BEAT_W-1:0]  start_beat;
      logic [BEAT_W-1:0]  length_beats;
      logic [7:0]         pitch;
      logic [VEL_W-1:0]   velocity;
      logic [TEMPO_W-1:0] tempo_us;
      logic               last_result;
   } result_type;

   // round(v * 2^14 / 127), using 2^14 = 129 * 127 + 1
   function automatic logic [VEL_W-1:0] vel_q14(input logic [7:0] v);
      logic [VEL_W-1:0] base;
      base = VEL_W'(v) * VEL_W'(129);
      return base + VEL_W'(v >= 8'd64) + VEL_W'(v >= 8'd191);
   endfunction

endpackage
`default_nettype wire

// ===== design/mtne_if.sv =====
`default_nettype none
interface mtne_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_track;
   logic       song_start;

   modport source (output valid, data_byte, end_of_track, song_start, input ready);
   modport sink (input valid, data_byte, end_of_track, song_start, output ready);
endinterface

interface mtne_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mtne_pkg::KIND_W-1:0]   kind;
   logic [mtne_pkg::BEAT_W-1:0]   start_beat;
   logic [mtne_pkg::BEAT_W-1:0]   length_beats;
   logic [7:0]                    pitch;
   logic [mtne_pkg::VEL_W-1:0]    velocity;
   logic [mtne_pkg::TEMPO_W-1:0]  tempo_us;
   logic                          last_result;

   modport source (output valid, kind, start_beat, length_beats, pitch, velocity,
                   tempo_us, last_result, input ready);
   modport sink (input valid, kind, start_beat, length_beats, pitch, velocity,
                 tempo_us, last_result, output ready);
endinterface
`default_nettype wire

// ===== design/mtne_cell.sv =====
`default_nettype none
module mtne_cell #(
   parameter int TICK_BITS = mtne_pkg::TICK_BITS_DEF
) (
   input  wire                        clock,
   input  mtne_pkg::cell_ctl_type     ctl,
   input  mtne_pkg::key_type          key,
   input  mtne_pkg::entry_type        next_entry,
   input  wire  [TICK_BITS-1:0]       next_start,
   input  mtne_pkg::entry_type        new_entry,
   input  wire  [TICK_BITS-1:0]       new_start,
   output mtne_pkg::entry_type        entry,
   output logic [TICK_BITS-1:0]       start_tick,
   output logic                       hit
);

   mtne_pkg::entry_type  entry_ff, entry_in;
   logic [TICK_BITS-1:0] start_ff, start_in;

   always_comb begin
      entry_in = entry_ff;
      start_in = start_ff;
      if (ctl.load) begin
         entry_in = new_entry;
         start_in = new_start;
      end else if (ctl.shift) begin
         entry_in = next_entry;
         start_in = next_start;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      start_ff <= start_in;
   end

   assign entry      = entry_ff;
   assign start_tick = start_ff;
   assign hit = ctl.occupied && (entry_ff.ch == key.ch) && (entry_ff.pitch == key.pitch);

endmodule
`default_nettype wire

// ===== design/mtne_div.sv =====
`default_nettype none
module mtne_div #(
   parameter int TICK_BITS     = mtne_pkg::TICK_BITS_DEF,
   parameter int FRACTION_BITS = mtne_pkg::FRACTION_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            start,
   input  wire  [TICK_BITS-1:0]           ticks,
   input  wire  [mtne_pkg::TPQ_W-1:0]     tpq,
   output logic                           busy,
   output logic [mtne_pkg::BEAT_W-1:0]    quotient
);

   localparam int NW = TICK_BITS + FRACTION_BITS + 2;
   localparam int CW = $clog2(NW + 1);
   localparam int DW = mtne_pkg::TPQ_W + 1;

   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;

   logic [mtne_pkg::TPQ_W-1:0] tpq_e;
   logic [DW:0]                rem_sh;
   logic                       ge;

   assign tpq_e  = (tpq == '0) ? mtne_pkg::TPQ_W'(1) : tpq;
   assign rem_sh = {rem_ff, num_ff[NW-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};

   // round half up: (2 * ticks * 2^F + tpq) / (2 * tpq), one quotient bit per cycle
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         num_in  = NW'({ticks, {(FRACTION_BITS + 1){1'b0}}}) + NW'(tpq_e);
         rem_in  = '0;
         den_in  = {tpq_e, 1'b0};
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], ge};
         rem_in = ge ? DW'(rem_sh - {1'b0, den_ff}) : DW'(rem_sh);
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign busy     = busy_ff;
   assign quotient = mtne_pkg::BEAT_W'(num_ff);

endmodule
`default_nettype wire

// ===== design/midi_track_note_extractor.sv =====
// one byte per transfer; a byte that closes no note passes the IMM, CLOSE, OPEN, EOT and
// FINISH states before the next byte is taken; each emitted note adds a run of the serial
// beat dividers and the NOTE state; a track end flushes the held notes in turn the same way
// results leave through a one-deep hold and an output register, each marked last when known
// reset (synchronous, active high) empties the note table and clears parsing state;
// ticks_per_quarter returns to 480 and the table entries themselves are left as they are
`default_nettype none
module midi_track_note_extractor #(
   parameter int PENDING_DEPTH = mtne_pkg::PENDING_DEPTH_DEF,
   parameter int TICK_BITS     = mtne_pkg::TICK_BITS_DEF,
   parameter int FRACTION_BITS = mtne_pkg::FRACTION_BITS_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   mtne_req_if.sink                     req_port,
   mtne_rsp_if.source                   rsp_port,
   input  wire                          csr_we,
   input  wire  [mtne_pkg::TPQ_W-1:0]   csr_wdata
);

   localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
   localparam int IDX_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
   localparam int SUM_W = ((TICK_BITS > mtne_pkg::NUM_W) ? TICK_BITS : mtne_pkg::NUM_W) + 1;
   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   // configuration
   logic [mtne_pkg::TPQ_W-1:0] tpq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpq_ff <= mtne_pkg::TPQ_RESET;
      end else if (csr_we) begin
         tpq_ff <= csr_wdata;
      end
   end

   // parser state
   logic [TICK_BITS-1:0]          tick_ff;
   logic [7:0]                    rs_ff;
   mtne_pkg::phase_type           phase_ff;
   logic [mtne_pkg::NUM_W-1:0]    acc_ff;
   logic [mtne_pkg::NBC_W-1:0]    nbc_ff;
   logic [mtne_pkg::NUM_W-1:0]    skip_ff;
   logic [7:0]                    meta_ff;
   logic [mtne_pkg::TEMPO_W-1:0]  tacc_ff;
   logic                          tseen_ff;
   logic                          err_ff;
   logic [7:0]                    first_ff;
   logic [CNT_W-1:0]              count_ff;

   // per-byte work list
   logic                          imm_valid_ff;
   mtne_pkg::kind_type            imm_kind_ff;
   logic                          close_ff;
   logic                          open_ff;
   mtne_pkg::key_type             key_ff;
   logic [7:0]                    key_vel_ff;
   logic                          eot_fail_ff;
   logic                          flush_ff;
   logic                          ret_flush_ff;
   logic [7:0]                    note_pitch_ff;
   logic [7:0]                    note_vel_ff;

   mtne_pkg::seq_state_type       state_ff, state_in;

   logic accept;
   assign accept = req_port.valid && req_port.ready;
   assign req_port.ready = (state_ff == mtne_pkg::SQ_IDLE);

   // parsing of the accepted byte
   logic [7:0]                    b;
   logic                          ss;
   logic [TICK_BITS-1:0]          cur_tick;
   logic [7:0]                    cur_rs;
   mtne_pkg::phase_type           cur_phase;
   logic [mtne_pkg::NUM_W-1:0]    cur_acc;
   logic [mtne_pkg::NBC_W-1:0]    cur_nbc;
   logic [mtne_pkg::NUM_W-1:0]    cur_skip;
   logic [7:0]                    cur_meta;
   logic [mtne_pkg::TEMPO_W-1:0]  cur_tacc;
   logic                          cur_tseen;
   logic                          cur_err;
   logic [7:0]                    cur_first;

   assign b  = req_port.data_byte;
   assign ss = req_port.song_start;
   assign cur_tick  = ss ? '0 : tick_ff;
   assign cur_rs    = ss ? '0 : rs_ff;
   assign cur_phase = ss ? mtne_pkg::PH_DELTA : phase_ff;
   assign cur_acc   = ss ? '0 : acc_ff;
   assign cur_nbc   = ss ? '0 : nbc_ff;
   assign cur_skip  = ss ? '0 : skip_ff;
   assign cur_meta  = ss ? '0 : meta_ff;
   assign cur_tacc  = ss ? '0 : tacc_ff;
   assign cur_tseen = ss ? 1'b0 : tseen_ff;
   assign cur_err   = ss ? 1'b0 : err_ff;
   assign cur_first = ss ? '0 : first_ff;

   logic [mtne_pkg::NUM_W-1:0]    acc_t;
   logic [mtne_pkg::NBC_W-1:0]    nbc_t;
   logic [SUM_W-1:0]              tick_sum;
   logic [TICK_BITS-1:0]          tick_sat;
   logic [mtne_pkg::NUM_W-1:0]    skip_m1;
   logic [mtne_pkg::TEMPO_W-1:0]  tacc_t;

   assign acc_t    = {cur_acc[mtne_pkg::NUM_W-8:0], b[6:0]};
   assign nbc_t    = cur_nbc + mtne_pkg::NBC_W'(1);
   assign tick_sum = SUM_W'(cur_tick) + SUM_W'(acc_t);
   assign tick_sat = (tick_sum > SUM_W'(TICK_MAX)) ? TICK_MAX : TICK_BITS'(tick_sum);
   assign skip_m1  = cur_skip - mtne_pkg::NUM_W'(1);
   assign tacc_t   = {cur_tacc[mtne_pkg::TEMPO_W-9:0], b};

   logic [TICK_BITS-1:0]          n_tick;
   logic [7:0]                    n_rs;
   mtne_pkg::phase_type           n_phase;
   logic [mtne_pkg::NUM_W-1:0]    n_acc;
   logic [mtne_pkg::NBC_W-1:0]    n_nbc;
   logic [mtne_pkg::NUM_W-1:0]    n_skip;
   logic [7:0]                    n_meta;
   logic [mtne_pkg::TEMPO_W-1:0]  n_tacc;
   logic                          n_tseen;
   logic [7:0]                    n_first;
   logic                          f_fail2, f_fail3, f_tempo, f_close, f_open;
   logic                          f_eot_fail, f_flush;

   always_comb begin
      n_tick  = cur_tick;
      n_rs    = cur_rs;
      n_phase = cur_phase;
      n_acc   = cur_acc;
      n_nbc   = cur_nbc;
      n_skip  = cur_skip;
      n_meta  = cur_meta;
      n_tacc  = cur_tacc;
      n_tseen = cur_tseen;
      n_first = cur_first;
      f_fail2 = 1'b0;
      f_fail3 = 1'b0;
      f_tempo = 1'b0;
      f_close = 1'b0;
      f_open  = 1'b0;
      if (!cur_err) begin
         case (cur_phase)
            mtne_pkg::PH_DELTA: begin
               n_acc = acc_t;
               n_nbc = nbc_t;
               if (!b[7]) begin
                  n_tick  = tick_sat;
                  n_nbc   = '0;
                  n_phase = mtne_pkg::PH_STATUS;
               end else if (nbc_t >= mtne_pkg::NUM_MAX_BYTES) begin
                  f_fail3 = 1'b1;
               end
            end
            mtne_pkg::PH_STATUS: begin
               if (!b[7]) begin
                  if (cur_rs == '0) begin
                     f_fail2 = 1'b1;
                  end else if (cur_rs[7:4] inside {mtne_pkg::NIB_PROGRAM,
                                                   mtne_pkg::NIB_PRESSURE}) begin
                     n_acc   = '0;
                     n_nbc   = '0;
                     n_phase = mtne_pkg::PH_DELTA;
                  end else begin
                     n_first = b;
                     n_phase = mtne_pkg::PH_DATA2;
                  end
               end else if (b == mtne_pkg::META_STATUS) begin
                  n_rs    = '0;
                  n_phase = mtne_pkg::PH_META_TYPE;
               end else if (b == mtne_pkg::SYSEX_STATUS || b == mtne_pkg::SYSEX_ESCAPE) begin
                  n_rs    = '0;
                  n_acc   = '0;
                  n_nbc   = '0;
                  n_phase = mtne_pkg::PH_SYSEX_LEN;
               end else begin
                  n_rs = b;
                  if (b[7:4] inside {mtne_pkg::NIB_PROGRAM, mtne_pkg::NIB_PRESSURE}) begin
                     n_phase = mtne_pkg::PH_ONE_DATA;
                  end else begin
                     n_phase = mtne_pkg::PH_DATA1;
                  end
               end
            end
            mtne_pkg::PH_DATA1: begin
               n_first = b;
               n_phase = mtne_pkg::PH_DATA2;
            end
            mtne_pkg::PH_DATA2: begin
               if (cur_rs[7:4] == mtne_pkg::NIB_ON && b != '0) begin
                  f_close = 1'b1;
                  f_open  = 1'b1;
               end else if (cur_rs[7:4] == mtne_pkg::NIB_ON ||
                            cur_rs[7:4] == mtne_pkg::NIB_OFF) begin
                  f_close = 1'b1;
               end
               n_acc   = '0;
               n_nbc   = '0;
               n_phase = mtne_pkg::PH_DELTA;
            end
            mtne_pkg::PH_META_TYPE: begin
               n_meta  = b;
               n_acc   = '0;
               n_nbc   = '0;
               n_phase = mtne_pkg::PH_META_LEN;
            end
            mtne_pkg::PH_META_LEN, mtne_pkg::PH_SYSEX_LEN: begin
               n_acc = acc_t;
               n_nbc = nbc_t;
               if (!b[7]) begin
                  n_skip  = acc_t;
                  n_nbc   = '0;
                  n_phase = (acc_t != '0) ? mtne_pkg::PH_SKIP : mtne_pkg::PH_DELTA;
                  if (cur_phase == mtne_pkg::PH_META_LEN && cur_meta == mtne_pkg::TEMPO_TYPE
                      && acc_t == mtne_pkg::NUM_W'(3) && !cur_tseen) begin
                     n_tacc  = '0;
                     n_phase = mtne_pkg::PH_TEMPO;
                  end
               end else if (nbc_t >= mtne_pkg::NUM_MAX_BYTES) begin
                  f_fail3 = 1'b1;
               end
            end
            mtne_pkg::PH_TEMPO: begin
               n_tacc = tacc_t;
               n_skip = skip_m1;
               if (skip_m1 == '0) begin
                  if (tacc_t != '0) begin
                     n_tseen = 1'b1;
                     f_tempo = 1'b1;
                  end
                  n_acc   = '0;
                  n_nbc   = '0;
                  n_phase = mtne_pkg::PH_DELTA;
               end
            end
            mtne_pkg::PH_SKIP: begin
               if (cur_skip != '0) begin
                  n_skip = skip_m1;
               end
               if (cur_skip == '0 || skip_m1 == '0) begin
                  n_acc   = '0;
                  n_nbc   = '0;
                  n_phase = mtne_pkg::PH_DELTA;
               end
            end
            default: begin
               n_acc   = '0;
               n_nbc   = '0;
               n_phase = mtne_pkg::PH_DELTA;
            end
         endcase
      end
   end

   always_comb begin
      f_eot_fail = 1'b0;
      f_flush    = 1'b0;
      if (req_port.end_of_track && !cur_err && !f_fail2 && !f_fail3) begin
         if (n_phase != mtne_pkg::PH_DELTA || n_nbc != '0) begin
            f_eot_fail = 1'b1;
         end else begin
            f_flush = 1'b1;
         end
      end
   end

   // note table: a row of cells that compacts toward cell 0
   mtne_pkg::entry_type   cell_entry [PENDING_DEPTH];
   logic [TICK_BITS-1:0]  cell_start [PENDING_DEPTH];
   logic [PENDING_DEPTH-1:0] hit;
   mtne_pkg::entry_type   new_entry;
   logic                  remove_en, append_en;
   logic [IDX_W-1:0]      remove_idx;

   assign new_entry.ch    = key_ff.ch;
   assign new_entry.pitch = key_ff.pitch;
   assign new_entry.vel   = key_vel_ff;

   for (genvar j = 0; j < PENDING_DEPTH; j++) begin : g_cell
      mtne_pkg::cell_ctl_type ctl;
      mtne_pkg::entry_type    nb_entry;
      logic [TICK_BITS-1:0]   nb_start;

      assign ctl.shift    = remove_en && (CNT_W'(j) >= CNT_W'(remove_idx));
      assign ctl.load     = append_en && (CNT_W'(j) == count_ff);
      assign ctl.occupied = CNT_W'(j) < count_ff;

      if (j < PENDING_DEPTH - 1) begin : g_mid
         assign nb_entry = cell_entry[j+1];
         assign nb_start = cell_start[j+1];
      end else begin : g_end
         assign nb_entry = cell_entry[j];
         assign nb_start = cell_start[j];
      end

      mtne_cell #(.TICK_BITS(TICK_BITS)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .key        (key_ff),
         .next_entry (nb_entry),
         .next_start (nb_start),
         .new_entry  (new_entry),
         .new_start  (tick_ff),
         .entry      (cell_entry[j]),
         .start_tick (cell_start[j]),
         .hit        (hit[j])
      );
   end

   logic             found;
   logic [IDX_W-1:0] match_idx;

   always_comb begin
      found     = 1'b0;
      match_idx = '0;
      for (int k = PENDING_DEPTH - 1; k >= 0; k--) begin
         if (hit[k]) begin
            found     = 1'b1;
            match_idx = IDX_W'(k);
         end
      end
   end

   assign remove_idx = (state_ff == mtne_pkg::SQ_FLUSH) ? '0 : match_idx;

   mtne_pkg::entry_type  sel_entry;
   logic [TICK_BITS-1:0] sel_start;
   logic                 sel_live;

   assign sel_entry = cell_entry[remove_idx];
   assign sel_start = cell_start[remove_idx];
   assign sel_live  = tick_ff > sel_start;

   // beat conversion
   logic                        div_start;
   logic                        busy0, busy1;
   logic [mtne_pkg::BEAT_W-1:0] q_start, q_len;

   mtne_div #(.TICK_BITS(TICK_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_start (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .ticks    (sel_start),
      .tpq      (tpq_ff),
      .busy     (busy0),
      .quotient (q_start)
   );

   mtne_div #(.TICK_BITS(TICK_BITS), .FRACTION_BITS(FRACTION_BITS)) u_div_len (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .ticks    (tick_ff - sel_start),
      .tpq      (tpq_ff),
      .busy     (busy1),
      .quotient (q_len)
   );

   // result hold and output register
   mtne_pkg::result_type hold_ff, out_ff;
   logic                 hold_valid_ff, out_valid_ff;
   logic                 slot_ok;
   logic                 produce, finish, restart, latch_note;
   mtne_pkg::result_type pdata;
   logic                 full;

   assign slot_ok = !hold_valid_ff || !out_valid_ff || rsp_port.ready;
   assign full    = count_ff >= CNT_W'(PENDING_DEPTH);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtne_pkg::SQ_IDLE: begin
            if (accept) begin
               state_in = mtne_pkg::SQ_IMM;
            end
         end
         mtne_pkg::SQ_IMM: begin
            if (!imm_valid_ff || slot_ok) begin
               state_in = mtne_pkg::SQ_CLOSE;
            end
         end
         mtne_pkg::SQ_CLOSE: begin
            if (close_ff && found && sel_live) begin
               state_in = mtne_pkg::SQ_DIV;
            end else begin
               state_in = mtne_pkg::SQ_OPEN;
            end
         end
         mtne_pkg::SQ_DIV: begin
            if (!busy0 && !busy1) begin
               state_in = mtne_pkg::SQ_NOTE;
            end
         end
         mtne_pkg::SQ_NOTE: begin
            if (slot_ok) begin
               state_in = ret_flush_ff ? mtne_pkg::SQ_FLUSH : mtne_pkg::SQ_OPEN;
            end
         end
         mtne_pkg::SQ_OPEN: begin
            if (!(open_ff && full) || slot_ok) begin
               state_in = mtne_pkg::SQ_EOT;
            end
         end
         mtne_pkg::SQ_EOT: begin
            if (eot_fail_ff) begin
               if (slot_ok) begin
                  state_in = mtne_pkg::SQ_FINISH;
               end
            end else if (flush_ff) begin
               state_in = mtne_pkg::SQ_FLUSH;
            end else begin
               state_in = mtne_pkg::SQ_FINISH;
            end
         end
         mtne_pkg::SQ_FLUSH: begin
            if (count_ff == '0) begin
               state_in = mtne_pkg::SQ_FINISH;
            end else if (sel_live) begin
               state_in = mtne_pkg::SQ_DIV;
            end
         end
         mtne_pkg::SQ_FINISH: begin
            if (!hold_valid_ff || slot_ok) begin
               state_in = mtne_pkg::SQ_IDLE;
            end
         end
         default: begin
            state_in = mtne_pkg::SQ_IDLE;
         end
      endcase
   end

   always_comb begin
      produce    = 1'b0;
      finish     = 1'b0;
      restart    = 1'b0;
      latch_note = 1'b0;
      remove_en  = 1'b0;
      append_en  = 1'b0;
      div_start  = 1'b0;
      pdata      = '0;
      case (state_ff)
         mtne_pkg::SQ_IMM: begin
            produce    = imm_valid_ff;
            pdata.kind = imm_kind_ff;
            if (imm_kind_ff == mtne_pkg::KIND_TEMPO) begin
               pdata.tempo_us = tacc_ff;
            end
         end
         mtne_pkg::SQ_CLOSE: begin
            if (close_ff && found) begin
               remove_en  = 1'b1;
               latch_note = 1'b1;
               div_start  = sel_live;
            end
         end
         mtne_pkg::SQ_NOTE: begin
            produce            = 1'b1;
            pdata.kind         = mtne_pkg::KIND_NOTE;
            pdata.start_beat   = q_start;
            pdata.length_beats = q_len;
            pdata.pitch        = note_pitch_ff;
            pdata.velocity     = mtne_pkg::vel_q14(note_vel_ff);
         end
         mtne_pkg::SQ_OPEN: begin
            if (open_ff) begin
               if (!full) begin
                  append_en = 1'b1;
               end else begin
                  produce        = 1'b1;
                  pdata.kind     = mtne_pkg::KIND_FULL;
                  pdata.pitch    = key_ff.pitch;
                  pdata.velocity = mtne_pkg::vel_q14(key_vel_ff);
               end
            end
         end
         mtne_pkg::SQ_EOT: begin
            produce    = eot_fail_ff;
            pdata.kind = mtne_pkg::KIND_TRUNC;
         end
         mtne_pkg::SQ_FLUSH: begin
            if (count_ff != '0) begin
               remove_en  = 1'b1;
               latch_note = 1'b1;
               div_start  = sel_live;
            end else begin
               restart = 1'b1;
            end
         end
         mtne_pkg::SQ_FINISH: begin
            finish = 1'b1;
         end
         default: begin
            produce = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= mtne_pkg::SQ_IDLE;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (produce && slot_ok) begin
            hold_valid_ff <= 1'b1;
            if (hold_valid_ff) begin
               out_valid_ff <= 1'b1;
            end else if (rsp_port.ready) begin
               out_valid_ff <= 1'b0;
            end
         end else if (finish && hold_valid_ff && slot_ok) begin
            hold_valid_ff <= 1'b0;
            out_valid_ff  <= 1'b1;
         end else if (rsp_port.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (produce && slot_ok) begin
         hold_ff <= pdata;
         if (hold_valid_ff) begin
            out_ff             <= hold_ff;
            out_ff.last_result <= 1'b0;
         end
      end else if (finish && hold_valid_ff && slot_ok) begin
         out_ff             <= hold_ff;
         out_ff.last_result <= 1'b1;
      end
   end

   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.kind         = out_ff.kind;
   assign rsp_port.start_beat   = out_ff.start_beat;
   assign rsp_port.length_beats = out_ff.length_beats;
   assign rsp_port.pitch        = out_ff.pitch;
   assign rsp_port.velocity     = out_ff.velocity;
   assign rsp_port.tempo_us     = out_ff.tempo_us;
   assign rsp_port.last_result  = out_ff.last_result;

   // parser and work list registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         rs_ff        <= '0;
         phase_ff     <= mtne_pkg::PH_DELTA;
         acc_ff       <= '0;
         nbc_ff       <= '0;
         skip_ff      <= '0;
         meta_ff      <= '0;
         tacc_ff      <= '0;
         tseen_ff     <= 1'b0;
         err_ff       <= 1'b0;
         first_ff     <= '0;
         count_ff     <= '0;
         imm_valid_ff <= 1'b0;
         imm_kind_ff  <= mtne_pkg::KIND_NOTE;
         close_ff     <= 1'b0;
         open_ff      <= 1'b0;
         eot_fail_ff  <= 1'b0;
         flush_ff     <= 1'b0;
         ret_flush_ff <= 1'b0;
      end else begin
         if (accept) begin
            tick_ff      <= n_tick;
            rs_ff        <= n_rs;
            phase_ff     <= n_phase;
            acc_ff       <= n_acc;
            nbc_ff       <= n_nbc;
            skip_ff      <= n_skip;
            meta_ff      <= n_meta;
            tacc_ff      <= n_tacc;
            tseen_ff     <= n_tseen;
            first_ff     <= n_first;
            err_ff       <= cur_err || f_fail2 || f_fail3 || f_eot_fail;
            imm_valid_ff <= f_fail2 || f_fail3 || f_tempo;
            imm_kind_ff  <= f_fail2 ? mtne_pkg::KIND_RS_ERR :
                            f_fail3 ? mtne_pkg::KIND_TRUNC : mtne_pkg::KIND_TEMPO;
            close_ff     <= f_close;
            open_ff      <= f_open;
            eot_fail_ff  <= f_eot_fail;
            flush_ff     <= f_flush;
            if (ss) begin
               count_ff <= '0;
            end
         end else if (restart) begin
            tick_ff  <= '0;
            rs_ff    <= '0;
            phase_ff <= mtne_pkg::PH_DELTA;
            acc_ff   <= '0;
            nbc_ff   <= '0;
            skip_ff  <= '0;
            meta_ff  <= '0;
            tacc_ff  <= '0;
            first_ff <= '0;
            count_ff <= '0;
         end else if (remove_en) begin
            count_ff <= count_ff - CNT_W'(1);
         end else if (append_en) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (div_start) begin
            ret_flush_ff <= (state_ff == mtne_pkg::SQ_FLUSH);
         end
      end
      if (accept) begin
         key_ff.ch    <= n_rs[3:0];
         key_ff.pitch <= cur_first;
         key_vel_ff   <= b;
      end
      if (latch_note) begin
         note_pitch_ff <= sel_entry.pitch;
         note_vel_ff   <= sel_entry.vel;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(PENDING_DEPTH))
      else $error("note table count beyond depth");

   a_idle_hold_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mtne_pkg::SQ_IDLE) |-> !hold_valid_ff)
      else $error("result left in hold while idle");

   a_remove_nonempty: assert property (@(posedge clock) disable iff (reset)
      remove_en |-> (count_ff != '0))
      else $error("remove from empty note table");

   a_append_room: assert property (@(posedge clock) disable iff (reset)
      append_en |-> (count_ff < CNT_W'(PENDING_DEPTH)))
      else $error("append to full note table");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (busy0 && busy1 && state_ff == mtne_pkg::SQ_DIV))
      else $error("divider start without wait");

endmodule
`default_nettype wire
